// ----- rtl/core/bsr_pkg.sv -----
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types and constants for the Ritter bounding sphere block.
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W      = 32;
  localparam int RAD_W        = 31;

  // Distances fit in 33 bits: coordinate differences stay below 2^32.
  localparam int DIST_W       = 33;
  localparam int SUMSQ_W      = 66;
  localparam int REM_W        = 37;
  localparam int STEP_CNT_W   = 6;
  localparam int SQRT_STEPS   = SUMSQ_W / 2;
  localparam int DIV_STEPS    = 32;

  typedef enum logic {
    SSU_SQRT,
    SSU_DIV
  } ssu_mode_t;

  typedef struct packed {
    logic              start;
    ssu_mode_t         mode;
    logic [SUMSQ_W-1:0] a;   // radicand, or numerator in the low bits
    logic [DIST_W-1:0]  b;   // divisor
  } ssu_req_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] result;
  } ssu_rsp_t;

  typedef enum logic [4:0] {
    S_LOAD,
    S_P1_RD,
    S_P1_UPD,
    S_AXIS,
    S_A_RD,
    S_A_CAP,
    S_B_CAP,
    S_P2_RD,
    S_P2_CAP,
    S_SQ_MUL,
    S_SQ_ACC,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_ROOT_DONE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MV_MUL,
    S_MV_ACC,
    S_NEXT,
    S_OUT
  } state_t;

endpackage

// ----- rtl/core/bsr_ssu.sv -----
// ----------------------------------------------------------------------------
// bsr_ssu
// Shift-subtract unit: integer square root or fraction divide, one bit a cycle.
// ----------------------------------------------------------------------------
module bsr_ssu (
  input  logic              clk,
  input  logic              rst,
  input  bsr_pkg::ssu_req_t req,
  output bsr_pkg::ssu_rsp_t rsp
);
  import bsr_pkg::*;

  logic [REM_W-1:0]      rem;
  logic [DIST_W-1:0]     res;
  logic [SUMSQ_W-1:0]    rad;
  logic [STEP_CNT_W-1:0] cnt;
  logic                  busy;
  logic                  done;
  ssu_mode_t             mode;

  logic [REM_W-1:0] cur;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] diff;
  logic             ge;

  // Square root brings down two radicand bits per step; the divide doubles
  // the remainder, with the divisor parked in the low radicand bits.
  always_comb begin
    if (mode == SSU_SQRT) begin
      cur   = {rem[REM_W-3:0], rad[SUMSQ_W-1 -: 2]};
      trial = {2'b00, res, 2'b01};
    end else begin
      cur   = {rem[REM_W-2:0], 1'b0};
      trial = {{(REM_W - DIST_W){1'b0}}, rad[DIST_W-1:0]};
    end
    ge   = (cur >= trial);
    diff = cur - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == '0);
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mode <= req.mode;
      res  <= '0;
      if (req.mode == SSU_SQRT) begin
        rem <= '0;
        rad <= req.a;
        cnt <= STEP_CNT_W'(SQRT_STEPS - 1);
      end else begin
        rem <= {{(REM_W - DIST_W){1'b0}}, req.a[DIST_W-1:0]};
        rad <= {{(SUMSQ_W - DIST_W){1'b0}}, req.b};
        cnt <= STEP_CNT_W'(DIV_STEPS - 1);
      end
    end else if (busy) begin
      rem <= ge ? diff : cur;
      res <= {res[DIST_W-2:0], ge};
      cnt <= cnt - 1'b1;
      if (mode == SSU_SQRT) begin
        rad <= {rad[SUMSQ_W-3:0], 2'b00};
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = res;

endmodule

// ----- rtl/core/bounding_sphere_ritter.sv -----
// ----------------------------------------------------------------------------
// bounding_sphere_ritter
// Ritter approximate bounding sphere over a streamed set of Q16.16 vertices.
// ----------------------------------------------------------------------------
// Vertices stream in one per cycle and are kept in an on-chip store of
// MAX_VERTICES entries; vertices past that are dropped and the result's
// overflow flag is set. The transaction with tlast closes the set (it is
// stored too, if room remains), after which the input is not ready until the
// sphere has been computed. Pass one scans the store, reading and then
// updating on each vertex, to find the extremes on each axis. Seeding sets
// the start sphere on the seed pair of the widest axis. Pass two visits each
// vertex in load order: a distance costs three squares on the shared 32x32
// multiplier, then a 33-step square root in the shift-subtract unit, and a
// vertex outside the sphere adds a 32-step divide and three center updates.
// The result is held in an output register, so loading of the next set
// starts as soon as the result is written there.
module bounding_sphere_ritter (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // vertex_x, vertex_y, vertex_z
  input  logic         s_tlast,   // last_vertex
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // center_x, center_y, center_z, radius, zero pad
  output logic         m_tuser    // overflow
);
  import bsr_pkg::*;

  state_t state, state_next;

  // Vertex store, one row per vertex, registered read.
  logic [3*COORD_W-1:0] mem [MAX_VERTICES];
  logic [3*COORD_W-1:0] rd_data;
  logic [ADDR_W-1:0]    rd_addr;

  logic [CNT_W-1:0]  count;
  logic              dropped;
  logic [ADDR_W-1:0] idx;
  logic              idx_last;
  logic [1:0]        k;
  logic              pass2;

  logic signed [COORD_W-1:0] ext_min [3];
  logic signed [COORD_W-1:0] ext_max [3];
  logic [ADDR_W-1:0]         imin [3];
  logic [ADDR_W-1:0]         imax [3];
  logic [ADDR_W-1:0]         ia, ib;

  logic signed [COORD_W-1:0] pt [3];
  logic signed [COORD_W-1:0] refp [3];
  logic signed [COORD_W-1:0] center [3];
  logic [DIST_W-1:0]         radius_w;
  logic [DIST_W-1:0]         dreg;
  logic [DIST_W-1:0]         nr;
  logic [31:0]               frac;
  logic [SUMSQ_W-1:0]        acc;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  ssu_req_t ssu_req;
  ssu_rsp_t ssu_rsp;

  logic signed [COORD_W:0] diff_k;
  logic [31:0]             mag_k;
  logic signed [COORD_W-1:0] ref_k;
  logic [COORD_W:0]        ext_w [3];
  logic                    out_load;

  bsr_ssu u_ssu (
    .clk (clk),
    .rst (rst),
    .req (ssu_req),
    .rsp (ssu_rsp)
  );

  assign idx_last = ({1'b0, idx} == (count - 1'b1));
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  // Difference of the selected vertex component against the distance
  // reference: the other seed vertex in pass one, the live center after.
  always_comb begin
    ref_k  = pass2 ? center[k] : refp[k];
    if (state == S_MV_MUL || state == S_MV_ACC) begin
      ref_k = center[k];
    end
    diff_k = {pt[k][COORD_W-1], pt[k]} - {ref_k[COORD_W-1], ref_k};
    mag_k  = diff_k[COORD_W] ? 32'(-diff_k) : diff_k[31:0];
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ext_w[j] = 33'({ext_max[j][COORD_W-1], ext_max[j]} -
                     {ext_min[j][COORD_W-1], ext_min[j]});
    end
  end

  // Sequencer: next state and control.
  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    rd_addr      = idx;
    mul_a        = mag_k;
    mul_b        = mag_k;
    ssu_req      = '0;
    ssu_req.mode = SSU_SQRT;
    unique case (state)
      S_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid && s_tlast) begin
          state_next = S_P1_RD;
        end
      end
      S_P1_RD:  state_next = S_P1_UPD;
      S_P1_UPD: state_next = idx_last ? S_AXIS : S_P1_RD;
      S_AXIS:   state_next = S_A_RD;
      S_A_RD: begin
        rd_addr    = ia;
        state_next = S_A_CAP;
      end
      S_A_CAP: begin
        rd_addr    = ib;
        state_next = S_B_CAP;
      end
      S_B_CAP:  state_next = S_SQ_MUL;
      S_P2_RD:  state_next = S_P2_CAP;
      S_P2_CAP: state_next = S_SQ_MUL;
      S_SQ_MUL: state_next = S_SQ_ACC;
      S_SQ_ACC: state_next = (k == 2'd2) ? S_ROOT_GO : S_SQ_MUL;
      S_ROOT_GO: begin
        ssu_req.start = 1'b1;
        ssu_req.mode  = SSU_SQRT;
        ssu_req.a     = acc;
        state_next    = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        if (ssu_rsp.done) begin
          state_next = S_ROOT_DONE;
        end
      end
      S_ROOT_DONE: begin
        if (!pass2) begin
          state_next = S_P2_RD;
        end else if (dreg <= radius_w) begin
          state_next = S_NEXT;
        end else begin
          state_next = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        ssu_req.start = 1'b1;
        ssu_req.mode  = SSU_DIV;
        ssu_req.a     = {{(SUMSQ_W - DIST_W){1'b0}}, dreg - nr};
        ssu_req.b     = dreg;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (ssu_rsp.done) begin
          state_next = S_MV_MUL;
        end
      end
      S_MV_MUL: begin
        mul_b      = frac;
        state_next = S_MV_ACC;
      end
      S_MV_ACC: state_next = (k == 2'd2) ? S_NEXT : S_MV_MUL;
      S_NEXT:   state_next = idx_last ? S_OUT : S_P2_RD;
      S_OUT: begin
        if (out_load) begin
          state_next = S_LOAD;
        end
      end
      default:  state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready && (count < CNT_W'(MAX_VERTICES))) begin
      mem[count[ADDR_W-1:0]] <= s_tdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      dropped  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (count < CNT_W'(MAX_VERTICES)) begin
          count <= count + 1'b1;
        end else begin
          dropped <= 1'b1;
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
        count    <= '0;
        dropped  <= 1'b0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        idx   <= '0;
        pass2 <= 1'b0;
      end
      S_P1_UPD: begin
        for (int j = 0; j < 3; j++) begin
          if (idx == '0) begin
            ext_min[j] <= rd_data[j*COORD_W +: COORD_W];
            ext_max[j] <= rd_data[j*COORD_W +: COORD_W];
            imin[j]    <= '0;
            imax[j]    <= '0;
          end else if ($signed(rd_data[j*COORD_W +: COORD_W]) > ext_max[j]) begin
            ext_max[j] <= rd_data[j*COORD_W +: COORD_W];
            imax[j]    <= idx;
          end else if ($signed(rd_data[j*COORD_W +: COORD_W]) < ext_min[j]) begin
            ext_min[j] <= rd_data[j*COORD_W +: COORD_W];
            imin[j]    <= idx;
          end
        end
        if (!idx_last) begin
          idx <= idx + 1'b1;
        end
      end
      S_AXIS: begin
        // Ties favor x, then y.
        if (ext_w[0] >= ext_w[1] && ext_w[0] >= ext_w[2]) begin
          ia <= imin[0];
          ib <= imax[0];
        end else if (ext_w[1] >= ext_w[2]) begin
          ia <= imin[1];
          ib <= imax[1];
        end else begin
          ia <= imin[2];
          ib <= imax[2];
        end
      end
      S_A_CAP: begin
        for (int j = 0; j < 3; j++) begin
          pt[j] <= rd_data[j*COORD_W +: COORD_W];
        end
      end
      S_B_CAP: begin
        // Midpoint of the seed pair, rounded toward zero.
        for (int j = 0; j < 3; j++) begin
          logic signed [COORD_W:0] sum;
          sum = {pt[j][COORD_W-1], pt[j]} +
                {rd_data[j*COORD_W + COORD_W-1], rd_data[j*COORD_W +: COORD_W]};
          sum = sum + {{COORD_W{1'b0}}, sum[COORD_W]};
          refp[j]   <= rd_data[j*COORD_W +: COORD_W];
          center[j] <= sum[COORD_W:1];
        end
        k   <= 2'd0;
        acc <= '0;
      end
      S_P2_CAP: begin
        for (int j = 0; j < 3; j++) begin
          pt[j] <= rd_data[j*COORD_W +: COORD_W];
        end
        k   <= 2'd0;
        acc <= '0;
      end
      S_SQ_ACC: begin
        acc <= acc + {{(SUMSQ_W - 64){1'b0}}, prod};
        k   <= k + 1'b1;
      end
      S_ROOT_WAIT: begin
        if (ssu_rsp.done) begin
          dreg <= ssu_rsp.result;
        end
      end
      S_ROOT_DONE: begin
        if (!pass2) begin
          radius_w <= {1'b0, dreg[DIST_W-1:1]};
          pass2    <= 1'b1;
          idx      <= '0;
        end else begin
          nr <= DIST_W'(({1'b0, radius_w} + {1'b0, dreg}) >> 1);
        end
      end
      S_DIV_WAIT: begin
        if (ssu_rsp.done) begin
          frac     <= ssu_rsp.result[31:0];
          radius_w <= nr;
          k        <= 2'd0;
        end
      end
      S_MV_ACC: begin
        // The step never exceeds the offset, so the center stays in range.
        if (diff_k[COORD_W]) begin
          center[k] <= COORD_W'({center[k][COORD_W-1], center[k]} -
                                {1'b0, prod[63:32]});
        end else begin
          center[k] <= COORD_W'({center[k][COORD_W-1], center[k]} +
                                {1'b0, prod[63:32]});
        end
        k <= k + 1'b1;
      end
      S_NEXT: begin
        if (!idx_last) begin
          idx <= idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata[31:0]   <= center[0];
      m_tdata[63:32]  <= center[1];
      m_tdata[95:64]  <= center[2];
      m_tdata[126:96] <= (radius_w[DIST_W-1:RAD_W] != '0) ? {RAD_W{1'b1}}
                                                          : radius_w[RAD_W-1:0];
      m_tdata[127]    <= 1'b0;
      m_tuser         <= dropped;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_VERTICES))
    else $error("vertex count past store capacity");

  a_ssu_done_wait: assert property (@(posedge clk) disable iff (rst)
    ssu_rsp.done |-> (state == S_ROOT_WAIT || state == S_DIV_WAIT))
    else $error("shift-subtract unit finished outside a wait state");

  a_out_restart: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (state == S_LOAD && count == '0 && m_tvalid))
    else $error("result write did not restart loading");

  // A point just one step outside leaves the halved radius unchanged.
  a_radius_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_WAIT && ssu_rsp.done) |-> (nr >= radius_w))
    else $error("sphere growth shrank the radius");

endmodule
